[rtl/core/stable_priority_queue_defines.svh]
// assertion helpers shared by the queue modules
`ifndef STABLE_PRIORITY_QUEUE_DEFINES_SVH
`define STABLE_PRIORITY_QUEUE_DEFINES_SVH

// property that must hold on every clock edge outside reset
`define SPQ_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// condition that must be followed by a consequence in the next cycle
`define SPQ_ASSERT_NEXT(lbl, cond, conseq, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) \
        (cond) |=> (conseq)) else $error(msg);

`endif

[rtl/core/spq_pkg.sv]
package spq_pkg;

    // queue geometry
    localparam int CAPACITY   = 16;
    localparam int NUM_LEVELS = 5;
    localparam int CNT_W      = $clog2(CAPACITY + 1);
    localparam int IDENT_W    = 31;
    localparam int LEVEL_W    = 3;
    localparam int FILL_W     = 5;

    localparam logic [LEVEL_W-1:0] LEVEL_MAX = LEVEL_W'(NUM_LEVELS - 1);
    localparam logic [CNT_W-1:0]   CNT_FULL  = CNT_W'(CAPACITY);

    // request kinds
    localparam logic KIND_ENQ = 1'b0;
    localparam logic KIND_DEQ = 1'b1;

    // result status codes
    typedef enum logic [1:0] {
        STAT_DONE  = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_EMPTY = 2'd2
    } spq_status_t;

    typedef struct packed {
        logic                kind;
        logic [LEVEL_W-1:0]  level;
        logic [IDENT_W-1:0]  ident_in;
    } spq_in_t;

    typedef struct packed {
        logic [1:0]          status;
        logic [IDENT_W-1:0]  ident_out;
        logic [LEVEL_W-1:0]  level_out;
        logic                now_empty;
        logic [FILL_W-1:0]   fill;
    } spq_out_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic exec;
    } spq_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic empty;
        logic full;
    } spq_sts_t;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } spq_state_t;

endpackage

[rtl/core/spq_datapath.sv]
`include "stable_priority_queue_defines.svh"

module spq_datapath
    import spq_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  spq_in_t  s_data,
    input  spq_cmd_t cmd,
    output spq_sts_t sts,
    output spq_out_t m_data
);

    spq_in_t              in_reg;
    spq_out_t             out_reg;
    spq_out_t             out_next;
    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;
    logic [IDENT_W-1:0]   slot_ident [CAPACITY];
    logic [LEVEL_W-1:0]   slot_level [CAPACITY];
    logic [LEVEL_W-1:0]   lvl_sat;
    logic [CAPACITY-1:0]  gt;
    logic [CAPACITY-1:0]  prev_gt;
    logic                 do_enq;
    logic                 do_deq;

    // captured request
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            in_reg <= s_data;
        end
    end

    assign sts.empty = (count_reg == '0);
    assign sts.full  = (count_reg == CNT_FULL);

    assign do_enq = cmd.exec && (in_reg.kind == KIND_ENQ) && !sts.full;
    assign do_deq = cmd.exec && (in_reg.kind == KIND_DEQ) && !sts.empty;

    // saturate the level to the highest defined one
    assign lvl_sat = (in_reg.level > LEVEL_MAX) ? LEVEL_MAX : in_reg.level;

    // per cell: the entry here goes behind the new one (or the cell is free)
    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            gt[i] = (CNT_W'(i) >= count_reg) || (slot_level[i] > lvl_sat);
        end
    end

    assign prev_gt = {gt[CAPACITY-2:0], 1'b0};

    // row of cells: keep, take the new entry, shift up on insert, shift down on removal
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [IDENT_W-1:0] below_ident;
        logic [LEVEL_W-1:0] below_level;
        logic [IDENT_W-1:0] above_ident;
        logic [LEVEL_W-1:0] above_level;

        if (g == 0) begin : g_first
            assign below_ident = '0;
            assign below_level = '0;
        end else begin : g_rest
            assign below_ident = slot_ident[g-1];
            assign below_level = slot_level[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign above_ident = slot_ident[g];
            assign above_level = slot_level[g];
        end else begin : g_inner
            assign above_ident = slot_ident[g+1];
            assign above_level = slot_level[g+1];
        end

        always_ff @(posedge aclk) begin
            if (do_enq) begin
                if (gt[g] && !prev_gt[g]) begin
                    slot_ident[g] <= in_reg.ident_in;
                    slot_level[g] <= lvl_sat;
                end else if (prev_gt[g]) begin
                    slot_ident[g] <= below_ident;
                    slot_level[g] <= below_level;
                end
            end else if (do_deq) begin
                slot_ident[g] <= above_ident;
                slot_level[g] <= above_level;
            end
        end
    end

    // fill count
    always_comb begin
        count_next = count_reg;
        if (do_enq) begin
            count_next = count_reg + CNT_W'(1);
        end else if (do_deq) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    // result word
    always_comb begin
        out_next.status    = STAT_DONE;
        out_next.ident_out = '0;
        out_next.level_out = '0;
        if (in_reg.kind == KIND_ENQ) begin
            if (sts.full) begin
                out_next.status = STAT_FULL;
            end
        end else begin
            if (sts.empty) begin
                out_next.status = STAT_EMPTY;
            end else begin
                out_next.ident_out = slot_ident[0];
                out_next.level_out = slot_level[0];
            end
        end
        out_next.now_empty = (count_next == '0);
        out_next.fill      = FILL_W'(count_next);
    end

    always_ff @(posedge aclk) begin
        if (cmd.exec) begin
            out_reg <= out_next;
        end
    end

    assign m_data = out_reg;

    `SPQ_ASSERT(a_count_bound, count_reg <= CNT_FULL, "fill count above capacity")
    `SPQ_ASSERT_NEXT(a_enq_grows, do_enq, count_reg == $past(count_reg) + CNT_W'(1),
        "accepted enqueue did not grow the queue")
    `SPQ_ASSERT_NEXT(a_deq_shrinks, do_deq, count_reg == $past(count_reg) - CNT_W'(1),
        "accepted dequeue did not shrink the queue")

endmodule

[rtl/core/spq_ctrl.sv]
`include "stable_priority_queue_defines.svh"

module spq_ctrl
    import spq_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    output logic     m_valid,
    input  logic     m_ready,
    input  spq_sts_t sts,
    output spq_cmd_t cmd
);

    spq_state_t state_reg;
    spq_state_t state_next;
    logic       m_valid_reg;
    logic       m_valid_next;
    logic       out_free;

    // result slot can take a new word this cycle
    assign out_free = !m_valid_reg || m_ready;

    assign s_ready  = (state_reg == S_IDLE);
    assign cmd.load = s_valid && s_ready;
    assign cmd.exec = (state_reg == S_EXEC) && out_free;

    // sequencing
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (cmd.load) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // result valid
    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.exec) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

    `SPQ_ASSERT(a_no_overwrite, !(cmd.exec && m_valid_reg && !m_ready),
        "result overwritten before it was taken")
    `SPQ_ASSERT_NEXT(a_exec_shows, cmd.exec, m_valid_reg, "executed request gave no result")
    `SPQ_ASSERT(a_status_sane, !(sts.empty && sts.full), "queue flagged empty and full at once")

endmodule

[rtl/core/stable_priority_queue.sv]
// Stable priority queue of up to CAPACITY entries (identifier and level).
// Input channel s_valid/s_ready/s_data carries one request: kind 0 enqueues
// ident_in at level (levels above NUM_LEVELS-1 are clamped), kind 1 dequeues
// the front entry. A smaller level leaves first; equal levels leave in order
// of arrival. Every request gives exactly one result on m_valid/m_ready/m_data
// with a status (done, full on enqueue, empty on dequeue), the dequeued entry
// (zero otherwise), an empty flag and the fill count after the request.
// A request accepted in S_IDLE is executed in S_EXEC once the result register
// is free; the result is registered and m_valid rises with it.
// A new request is not taken until the previous one has been executed; the
// entries sit in a row of cells that keep, shift or insert together when the
// request executes.
// A new request is taken while the previous result still waits for m_ready;
// if the receiver stalls, execution of that request waits until the result
// register is free, and s_ready stays low meanwhile.
// Reset (aresetn low, synchronous) empties the queue and drops any pending
// result; no clearing pass is needed.
module stable_priority_queue
    import spq_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  spq_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output spq_out_t m_data
);

    spq_cmd_t cmd;
    spq_sts_t sts;

    spq_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    spq_datapath u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cmd     (cmd),
        .sts     (sts),
        .m_data  (m_data)
    );

endmodule
